@@ src/ffbp_pkg.sv @@
`default_nettype none

package ffbp_pkg;

  // Field widths
  localparam int WEIGHT_W     = 16;
  localparam int BIN_INDEX_W  = 8;
  localparam int BINS_USED_W  = 9;

  // Defaults
  localparam int          MAX_BINS_DEFAULT = 256;
  localparam logic [15:0] CAPACITY_RESET   = 16'd100;

  // Scan sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } scan_state_t;

  // One result word, handed from the scan engine to the output register
  typedef struct packed {
    logic [BIN_INDEX_W-1:0] bin_index;
    logic                   opened_new;
    logic                   rejected;
    logic [BINS_USED_W-1:0] bins_used;
  } result_t;

endpackage

`default_nettype wire

@@ src/ffbp_ram.sv @@
`default_nettype none

module ffbp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Simple dual port, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ src/ffbp_scan.sv @@
`default_nettype none

module ffbp_scan
  import ffbp_pkg::*;
#(
  parameter int MAX_BINS = MAX_BINS_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [WEIGHT_W-1:0]         capacity,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [WEIGHT_W-1:0]         item_weight,
  output logic                             ram_wr_en,
  output logic [$clog2(MAX_BINS)-1:0]      ram_wr_addr,
  output logic [WEIGHT_W-1:0]              ram_wr_data,
  output logic [$clog2(MAX_BINS)-1:0]      ram_rd_addr,
  input  wire logic [WEIGHT_W-1:0]         ram_rd_data,
  output logic                             res_valid,
  input  wire logic                        res_take,
  output result_t                          res
);

  localparam int BW = $clog2(MAX_BINS);
  localparam int CW = $clog2(MAX_BINS + 1);

  scan_state_t         state, state_next;
  logic [WEIGHT_W-1:0] weight, weight_next;
  logic [BW-1:0]       scan_k, scan_k_next;
  logic [CW-1:0]       open_bins, open_bins_next;
  result_t             res_next;

  logic [WEIGHT_W:0]   sum;
  logic                fits;
  logic                last;
  logic                full;

  // Fill check on the word just read back
  assign sum  = {1'b0, ram_rd_data} + {1'b0, weight};
  assign fits = sum <= {1'b0, capacity};
  assign last = (CW'(scan_k) + CW'(1)) == open_bins;
  assign full = open_bins == CW'(MAX_BINS);

  // State and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      open_bins <= CW'(1);
    end else begin
      state     <= state_next;
      open_bins <= open_bins_next;
    end
    weight <= weight_next;
    scan_k <= scan_k_next;
    res    <= res_next;
  end

  // Next state, memory access and result
  always_comb begin
    state_next     = state;
    weight_next    = weight;
    scan_k_next    = scan_k;
    open_bins_next = open_bins;
    res_next       = res;
    in_stall       = 1'b1;
    res_valid      = 1'b0;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = scan_k;
    ram_wr_data    = sum[WEIGHT_W-1:0];
    ram_rd_addr    = '0;
    case (state)
      ST_IDLE: begin
        in_stall    = 1'b0;
        ram_rd_addr = '0;
        if (in_valid) begin
          weight_next = item_weight;
          scan_k_next = '0;
          if (item_weight > capacity) begin
            res_next.bin_index  = '0;
            res_next.opened_new = 1'b0;
            res_next.rejected   = 1'b1;
            res_next.bins_used  = BINS_USED_W'(open_bins);
            state_next          = ST_FIN;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // read one bin ahead while checking the current one
        ram_rd_addr = scan_k + BW'(1);
        if (fits) begin
          ram_wr_en           = 1'b1;
          ram_wr_addr         = scan_k;
          ram_wr_data         = sum[WEIGHT_W-1:0];
          res_next.bin_index  = BIN_INDEX_W'(scan_k);
          res_next.opened_new = 1'b0;
          res_next.rejected   = 1'b0;
          res_next.bins_used  = BINS_USED_W'(open_bins);
          state_next          = ST_FIN;
        end else if (last) begin
          if (!full) begin
            // open the next bin with this item
            ram_wr_en           = 1'b1;
            ram_wr_addr         = open_bins[BW-1:0];
            ram_wr_data         = weight;
            open_bins_next      = open_bins + CW'(1);
            res_next.bin_index  = BIN_INDEX_W'(open_bins);
            res_next.opened_new = 1'b1;
            res_next.rejected   = 1'b0;
            res_next.bins_used  = BINS_USED_W'(open_bins + CW'(1));
          end else begin
            res_next.bin_index  = '0;
            res_next.opened_new = 1'b0;
            res_next.rejected   = 1'b1;
            res_next.bins_used  = BINS_USED_W'(open_bins);
          end
          state_next = ST_FIN;
        end else begin
          scan_k_next = scan_k + BW'(1);
        end
      end
      ST_FIN: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    // Bin zero is open from reset, so clear its fill; later bins are written when opened
    if (rst) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = '0;
      ram_wr_data = '0;
    end
  end

`ifndef SYNTH
  // Scan never looks past the open bins
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> CW'(scan_k) < open_bins)
    else $error("scan index beyond open bins");

  // Open count stays within the store
  a_open_range: assert property (@(posedge clk) disable iff (rst)
    open_bins != '0 && open_bins <= CW'(MAX_BINS))
    else $error("open bin count out of range");

  // Open count only grows, one bin at a time
  a_open_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (open_bins == $past(open_bins) || open_bins == $past(open_bins) + CW'(1)))
    else $error("open bin count jumped");

  // Fill store is written only while scanning
  a_write_scan: assert property (@(posedge clk) disable iff (rst)
    ram_wr_en |-> state == ST_SCAN)
    else $error("fill write outside scan");

  // A rejected word never opens a bin
  a_reject_no_open: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.rejected |-> !res.opened_new)
    else $error("rejected word opened a bin");
`endif

endmodule

`default_nettype wire

@@ src/first_fit_bin_packer_core.sv @@
// Flow: an accepted word is checked against the open bins in order from bin zero, stopping at
//   the first that fits, else it opens a new bin or is rejected; an overweight word skips the scan.
// A new input word is taken only once the last result has moved to the output register;
//   the scan pace is set by the fill memory's single read port, one bin checked per cycle.
// A finished word waits in the output register while the next input word is scanned.
// Reset (rst, synchronous): one bin open, bin zero's fill cleared, capacity 100.
`default_nettype none

module first_fit_bin_packer_core
  import ffbp_pkg::*;
#(
  parameter int MAX_BINS = MAX_BINS_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_wr_en,
  input  wire logic [WEIGHT_W-1:0]    cfg_wr_data,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [WEIGHT_W-1:0]    item_weight,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [BIN_INDEX_W-1:0]      bin_index,
  output logic                        opened_new,
  output logic                        rejected,
  output logic [BINS_USED_W-1:0]      bins_used
);

  localparam int BW = $clog2(MAX_BINS);

  logic [WEIGHT_W-1:0] bin_capacity;
  logic                ram_wr_en;
  logic [BW-1:0]       ram_wr_addr;
  logic [WEIGHT_W-1:0] ram_wr_data;
  logic [BW-1:0]       ram_rd_addr;
  logic [WEIGHT_W-1:0] ram_rd_data;
  logic                res_valid;
  logic                res_take;
  result_t             res;
  result_t             out_word;

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_capacity <= CAPACITY_RESET;
    end else if (cfg_wr_en) begin
      bin_capacity <= cfg_wr_data;
    end
  end

  // Fill level store
  ffbp_ram #(
    .WIDTH (WEIGHT_W),
    .DEPTH (MAX_BINS)
  ) u_fill_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // First-fit scan engine
  ffbp_scan #(
    .MAX_BINS (MAX_BINS)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .capacity    (bin_capacity),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .item_weight (item_weight),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data),
    .res_valid   (res_valid),
    .res_take    (res_take),
    .res         (res)
  );

  // Output register, loads when empty or draining
  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (res_take) begin
      out_word <= res;
    end
  end

  assign bin_index  = out_word.bin_index;
  assign opened_new = out_word.opened_new;
  assign rejected   = out_word.rejected;
  assign bins_used  = out_word.bins_used;

endmodule

`default_nettype wire
